// ===== hdl/fpid_pkg.sv =====
// Shared constants for the fixed-point PID unit: sample, gain and fraction
// widths, derived datapath widths, reset values and register indexes.
// No dependencies.
package fpid_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 10;
    localparam int GAIN_BITS   = 16;

    // Datapath widths, all full precision.
    localparam int ERR_W     = SAMPLE_BITS + 1;
    localparam int DIFF_W    = SAMPLE_BITS + 2;
    localparam int PROD_W    = GAIN_BITS + ERR_W;
    localparam int DPROD_W   = GAIN_BITS + DIFF_W;
    localparam int LIMIT_W   = SAMPLE_BITS - 1 + FRAC_BITS;
    localparam int ACC_W     = LIMIT_W + 1;
    localparam int ACC_SUM_W = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;
    localparam int SUM_W     = ((DPROD_W > ACC_SUM_W) ? DPROD_W : ACC_SUM_W) + 2;

    // Configuration port.
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W  = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ACCUM_LIMIT   = 3'd5;

    // Reset values.
    localparam logic [SAMPLE_BITS-1:0] FLOOR_RST   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] CEILING_RST = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [LIMIT_W-1:0]     LIMIT_RST   =
        {{(SAMPLE_BITS-1){1'b1}}, {FRAC_BITS{1'b0}}};

endpackage

// ===== hdl/fixed_point_pid_unit.sv =====
// Top level of the fixed-point PID unit: APB-style register file, two-stage
// sample datapath and valid/ready handshakes.
// Depends on fpid_pkg.

// Fixed-point PID controller. Each beat on the s_ channel carries a target and
// a sensed sample; the unit returns one m_drive beat per sample, in order.
// The error (target - sensed) is formed at full width. The proportional term
// is floor(prop_gain * error / 2^10); the integral accumulator adds
// integ_gain * error and is clamped to +/- accum_limit, then floored by 2^10;
// the derivative term is floor(deriv_gain * (error - previous error) / 2^10).
// The sum is clamped to drive_floor first, then drive_ceiling. Gains are
// signed Q10. Throughput is one sample per clock while m_ready is not held
// low; m_valid rises once a sample has moved from the stage-one registers
// into the output register. Stage one registers the error and the three
// gain products; stage two (the output register) folds the integral product
// into the accumulator, sums and clamps. The accumulator update in stage two
// is the loop that fixes the rate at one sample per clock. Registers sit at
// byte addresses 0 (prop_gain), 4 (integ_gain), 8 (deriv_gain),
// 12 (drive_floor), 16 (drive_ceiling), 20 (accum_limit); paddr[1:0] is
// ignored, and other word addresses ignore writes and read zero. Write
// registers only while no sample is in flight.
module fixed_point_pid_unit (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // APB-style configuration port
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [fpid_pkg::PADDR_W-1:0]             paddr,
    input  logic [fpid_pkg::PDATA_W-1:0]             pwdata,
    output logic [fpid_pkg::PDATA_W-1:0]             prdata,
    output logic                                     pready,
    // sample input
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [fpid_pkg::SAMPLE_BITS-1:0]  s_target,
    input  logic signed [fpid_pkg::SAMPLE_BITS-1:0]  s_sensed,
    // drive output
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [fpid_pkg::SAMPLE_BITS-1:0]  m_drive
);
    import fpid_pkg::*;

    // Configuration registers
    logic signed [GAIN_BITS-1:0]   prop_gain_reg;
    logic signed [GAIN_BITS-1:0]   integ_gain_reg;
    logic signed [GAIN_BITS-1:0]   deriv_gain_reg;
    logic signed [SAMPLE_BITS-1:0] drive_floor_reg;
    logic signed [SAMPLE_BITS-1:0] drive_ceiling_reg;
    logic        [LIMIT_W-1:0]     accum_limit_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    // Stage one: error, difference and gain products
    logic                      st1_valid_reg;
    logic signed [PROD_W-1:0]  prod_p_reg;
    logic signed [PROD_W-1:0]  prod_i_reg;
    logic signed [DPROD_W-1:0] prod_d_reg;
    logic signed [ERR_W-1:0]   last_error_reg;

    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic                      in_accept;

    // Stage two: accumulator and output register
    logic                        m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] drive_reg;
    logic signed [ACC_W-1:0]     accum_reg;
    logic signed [ACC_W-1:0]     accum_next;
    logic signed [SAMPLE_BITS-1:0] drive_next;

    logic signed [ACC_SUM_W-1:0] acc_sum;
    logic signed [ACC_SUM_W-1:0] acc_hi;
    logic signed [ACC_SUM_W-1:0] acc_lo;
    logic signed [PROD_W-1:0]    p_term;
    logic signed [ACC_W-1:0]     i_term;
    logic signed [DPROD_W-1:0]   d_term;
    logic signed [SUM_W-1:0]     sum;
    logic                        out_advance;

    // ------------------------------------------------------------------
    // Configuration port: zero-wait writes in the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            drive_floor_reg   <= FLOOR_RST;
            drive_ceiling_reg <= CEILING_RST;
            accum_limit_reg   <= LIMIT_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_PROP_GAIN:     prop_gain_reg     <= pwdata[GAIN_BITS-1:0];
                REG_INTEG_GAIN:    integ_gain_reg    <= pwdata[GAIN_BITS-1:0];
                REG_DERIV_GAIN:    deriv_gain_reg    <= pwdata[GAIN_BITS-1:0];
                REG_DRIVE_FLOOR:   drive_floor_reg   <= pwdata[SAMPLE_BITS-1:0];
                REG_DRIVE_CEILING: drive_ceiling_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_ACCUM_LIMIT:   accum_limit_reg   <= pwdata[LIMIT_W-1:0];
                default: ;  // drop writes to unused addresses
            endcase
        end
    end

    // Read back: signed registers come back sign-extended
    always_comb begin
        unique case (cfg_idx)
            REG_PROP_GAIN:     prdata = PDATA_W'(prop_gain_reg);
            REG_INTEG_GAIN:    prdata = PDATA_W'(integ_gain_reg);
            REG_DERIV_GAIN:    prdata = PDATA_W'(deriv_gain_reg);
            REG_DRIVE_FLOOR:   prdata = PDATA_W'(drive_floor_reg);
            REG_DRIVE_CEILING: prdata = PDATA_W'(drive_ceiling_reg);
            REG_ACCUM_LIMIT:   prdata = PDATA_W'(accum_limit_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: each stage advances when the one after it is empty or
    // moving, so a waiting result blocks the input only once stage one is full.
    // ------------------------------------------------------------------
    assign out_advance = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready     = !st1_valid_reg || out_advance;
    assign in_accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (in_accept) begin
                st1_valid_reg <= 1'b1;
            end else if (out_advance) begin
                st1_valid_reg <= 1'b0;
            end
            if (out_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage one: error at full width, change in error, three products
    // ------------------------------------------------------------------
    assign err  = ERR_W'(s_target) - ERR_W'(s_sensed);
    assign diff = DIFF_W'(err) - DIFF_W'(last_error_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
        end else if (in_accept) begin
            last_error_reg <= err;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            prod_p_reg <= PROD_W'(prop_gain_reg) * PROD_W'(err);
            prod_i_reg <= PROD_W'(integ_gain_reg) * PROD_W'(err);
            prod_d_reg <= DPROD_W'(deriv_gain_reg) * DPROD_W'(diff);
        end
    end

    // ------------------------------------------------------------------
    // Stage two: clamp the accumulator, floor each term, sum and clamp
    // ------------------------------------------------------------------
    assign acc_hi  = ACC_SUM_W'($signed({1'b0, accum_limit_reg}));
    assign acc_lo  = -acc_hi;
    assign acc_sum = ACC_SUM_W'(accum_reg) + ACC_SUM_W'(prod_i_reg);

    always_comb begin
        priority if (acc_sum < acc_lo) begin
            accum_next = ACC_W'(acc_lo);
        end else if (acc_sum > acc_hi) begin
            accum_next = ACC_W'(acc_hi);
        end else begin
            accum_next = ACC_W'(acc_sum);
        end
    end

    // Arithmetic shifts floor toward minus infinity
    assign p_term = prod_p_reg >>> FRAC_BITS;
    assign i_term = accum_next >>> FRAC_BITS;
    assign d_term = prod_d_reg >>> FRAC_BITS;
    assign sum    = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

    // Floor is tested first, so a floor above the ceiling wins on low sums
    always_comb begin
        priority if (sum < SUM_W'(drive_floor_reg)) begin
            drive_next = drive_floor_reg;
        end else if (sum > SUM_W'(drive_ceiling_reg)) begin
            drive_next = drive_ceiling_reg;
        end else begin
            drive_next = sum[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
        end else if (out_advance) begin
            accum_reg <= accum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_advance) begin
            drive_reg <= drive_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_drive = drive_reg;

endmodule
